FILE: design/ncofs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ncofs_pkg
// Shared constants and functions for the NCO frequency shifter: default
// sizes, mode codes, sine table generation and output rounding.
// ----------------------------------------------------------------------------
package ncofs_pkg;

	localparam int DEF_TABLE_ADDR_BITS = 10;
	localparam int DEF_PHASE_BITS      = 32;
	localparam int SAMPLE_W            = 16;
	localparam int STEP_W              = 32;

	localparam logic [STEP_W-1:0] PHASE_STEP_RESET = 32'd805306368;

	// pi/2 and 1.0 in Q2.30
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint ONE_Q30     = 64'sd1073741824;

	// Taylor series divisors (2n)(2n+1) for n = 1..9
	localparam longint TAYLOR_DIV [1:9] = '{
		64'sd6, 64'sd20, 64'sd42, 64'sd72, 64'sd110,
		64'sd156, 64'sd210, 64'sd272, 64'sd342
	};

	typedef enum logic {
		OP_UP   = 1'b0,
		OP_DOWN = 1'b1
	} op_t;

	// Quarter-wave table value for angle x (Q2.30, 0..pi/2); elaboration only.
	function automatic logic [SAMPLE_W-1:0] quarter_value(input longint x);
		longint x2;
		longint term;
		longint sum;
		longint v;
		x2   = (x * x) / ONE_Q30;
		term = x;
		sum  = x;
		for (int n = 1; n <= 9; n++) begin
			term = (term * x2) / ONE_Q30;
			term = term / TAYLOR_DIV[n];
			if ((n % 2) == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		v = (sum * 64'sd32767 + (ONE_Q30 / 2)) / ONE_Q30;
		if (v > 64'sd32767) begin
			v = 64'sd32767;
		end
		return v[SAMPLE_W-1:0];
	endfunction

	// Round half up by 2^15 and saturate a Q2.30 value to Q1.15.
	function automatic logic signed [SAMPLE_W-1:0] round_sat(input logic signed [32:0] v);
		logic signed [33:0] t;
		logic signed [18:0] r;
		t = 34'(v) + 34'sd16384;
		r = 19'(t >>> 15);
		if (r > 19'sd32767) begin
			return 16'sh7fff;
		end else if (r < -19'sd32768) begin
			return 16'sh8000;
		end else begin
			return r[SAMPLE_W-1:0];
		end
	endfunction

endpackage
`default_nettype wire

FILE: design/ncofs_sincos.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ncofs_sincos
// Sine and cosine lookup from a constant quarter-wave table. The cosine is
// read a quarter turn ahead of the sine index.
// ----------------------------------------------------------------------------
module ncofs_sincos #(
	parameter int TABLE_ADDR_BITS = ncofs_pkg::DEF_TABLE_ADDR_BITS
) (
	input  wire logic [TABLE_ADDR_BITS-1:0]           idx,
	output logic signed [ncofs_pkg::SAMPLE_W-1:0]     sin_val,
	output logic signed [ncofs_pkg::SAMPLE_W-1:0]     cos_val
);
	import ncofs_pkg::*;

	localparam int     QUARTER = 2 ** (TABLE_ADDR_BITS - 2);
	localparam int     QA_W    = TABLE_ADDR_BITS - 1;
	localparam logic [TABLE_ADDR_BITS-1:0] QUARTER_OFS = {2'b01, {(TABLE_ADDR_BITS-2){1'b0}}};
	localparam logic [QA_W-1:0]            QUARTER_IDX = {1'b1, {(QA_W-1){1'b0}}};

	logic [SAMPLE_W-1:0] qtab [0:QUARTER];

	for (genvar g = 0; g <= QUARTER; g++) begin : g_qtab
		localparam longint ANGLE = (longint'(g) * HALF_PI_Q30) / QUARTER;
		localparam logic [SAMPLE_W-1:0] VAL = quarter_value(ANGLE);
		assign qtab[g] = VAL;
	end

	logic [TABLE_ADDR_BITS-1:0]  lane_idx [0:1];
	logic signed [SAMPLE_W-1:0]  lane_val [0:1];

	assign lane_idx[0] = idx;
	assign lane_idx[1] = idx + QUARTER_OFS;

	for (genvar k = 0; k < 2; k++) begin : g_lane
		logic [1:0]            quad;
		logic [QA_W-1:0]       r;
		logic [QA_W-1:0]       addr;
		logic signed [SAMPLE_W-1:0] mag;

		assign quad = lane_idx[k][TABLE_ADDR_BITS-1 -: 2];
		assign r    = {1'b0, lane_idx[k][TABLE_ADDR_BITS-3:0]};
		// odd quadrants run the quarter wave backwards
		assign addr = quad[0] ? (QUARTER_IDX - r) : r;
		assign mag  = qtab[addr];
		assign lane_val[k] = quad[1] ? -mag : mag;
	end

	assign sin_val = lane_val[0];
	assign cos_val = lane_val[1];

endmodule
`default_nettype wire

FILE: design/nco_complex_frequency_shifter_core.sv
// An accepted input transaction passes the input stage and the result stage to out_valid.
// Throughput: one transaction per cycle unless out_stall holds the pipeline; the phase
// accumulators, the table lookup and the two multipliers each take one pass per sample.
// Reset (arst_n low): both phase accumulators clear to zero, phase_step returns
// to 805306368, and the pipeline empties.
`default_nettype none
// ----------------------------------------------------------------------------
// nco_complex_frequency_shifter_core
// NCO driven mixer: complex-to-real up-shift or real-to-complex down-shift,
// one phase accumulator per direction, rounded and saturated Q1.15 results.
// ----------------------------------------------------------------------------
module nco_complex_frequency_shifter_core #(
	parameter int TABLE_ADDR_BITS = ncofs_pkg::DEF_TABLE_ADDR_BITS,
	parameter int PHASE_BITS      = ncofs_pkg::DEF_PHASE_BITS
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_wr_en,
	input  wire logic [ncofs_pkg::STEP_W-1:0]          cfg_wr_data,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic                                  op,
	input  wire logic signed [ncofs_pkg::SAMPLE_W-1:0] in_i,
	input  wire logic signed [ncofs_pkg::SAMPLE_W-1:0] in_q,
	input  wire logic                                  block_end,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic signed [ncofs_pkg::SAMPLE_W-1:0]      out_i,
	output logic signed [ncofs_pkg::SAMPLE_W-1:0]      out_q,
	output logic                                       out_block_end
);
	import ncofs_pkg::*;

	logic [STEP_W-1:0]          phase_step_q;
	logic [PHASE_BITS-1:0]      up_phase_q;
	logic [PHASE_BITS-1:0]      down_phase_q;
	logic [PHASE_BITS+STEP_W-1:0] step_wide;
	logic [PHASE_BITS-1:0]      step_aligned;
	logic [PHASE_BITS-1:0]      cur_phase;

	logic                       valid_s1;
	logic                       op_s1;
	logic signed [SAMPLE_W-1:0] in_i_s1;
	logic signed [SAMPLE_W-1:0] in_q_s1;
	logic                       block_end_s1;
	logic [TABLE_ADDR_BITS-1:0] idx_s1;

	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_i_q;
	logic signed [SAMPLE_W-1:0] out_q_q;
	logic                       out_block_end_q;

	logic                       out_adv;
	logic                       in_acc;

	logic signed [SAMPLE_W-1:0] sin_v;
	logic signed [SAMPLE_W-1:0] cos_v;
	logic signed [SAMPLE_W-1:0] mul_b;
	logic signed [31:0]         prod_c;
	logic signed [31:0]         prod_s;
	logic signed [32:0]         res_i;
	logic signed [32:0]         res_q;

	// step << PHASE_BITS, then drop 32 bits: covers narrow and wide accumulators
	assign step_wide    = {phase_step_q, {PHASE_BITS{1'b0}}};
	assign step_aligned = step_wide[PHASE_BITS+STEP_W-1 -: PHASE_BITS];
	assign cur_phase    = (op == OP_DOWN) ? down_phase_q : up_phase_q;

	assign out_adv  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !out_adv;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= PHASE_STEP_RESET;
		end else if (cfg_wr_en) begin
			phase_step_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_phase_q   <= '0;
			down_phase_q <= '0;
		end else if (in_acc) begin
			if (op == OP_DOWN) begin
				down_phase_q <= down_phase_q + step_aligned;
			end else begin
				up_phase_q <= up_phase_q + step_aligned;
			end
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1        <= op;
			in_i_s1      <= in_i;
			in_q_s1      <= in_q;
			block_end_s1 <= block_end;
			idx_s1       <= cur_phase[PHASE_BITS-1 -: TABLE_ADDR_BITS];
		end
	end

	ncofs_sincos #(
		.TABLE_ADDR_BITS(TABLE_ADDR_BITS)
	) u_sincos (
		.idx     (idx_s1),
		.sin_val (sin_v),
		.cos_val (cos_v)
	);

	assign mul_b  = (op_s1 == OP_DOWN) ? in_i_s1 : in_q_s1;
	assign prod_c = in_i_s1 * cos_v;
	assign prod_s = mul_b * sin_v;

	always_comb begin
		if (op_s1 == OP_DOWN) begin
			res_i = 33'(prod_c);
			res_q = -33'(prod_s);
		end else begin
			res_i = 33'(prod_c) - 33'(prod_s);
			res_q = '0;
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && valid_s1) begin
			out_i_q         <= round_sat(res_i);
			out_q_q         <= round_sat(res_q);
			out_block_end_q <= block_end_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_i         = out_i_q;
	assign out_q         = out_q_q;
	assign out_block_end = out_block_end_q;

	// back-pressure only when both stages hold data
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q))
		else $error("input stalled with a free pipeline slot");

	a_down_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && op == OP_UP) |=> $stable(down_phase_q))
		else $error("down phase moved on an up-shift transaction");

	a_up_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && op == OP_DOWN) |=> $stable(up_phase_q))
		else $error("up phase moved on a down-shift transaction");

	a_s1_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && in_stall) |=> valid_s1)
		else $error("stage 1 transaction dropped while stalled");

endmodule
`default_nettype wire
